### rtl/srct_pkg.sv
// ----------------------------------------------------------------------------
// srct_pkg
// Shared types and constants for the split saturating reference counter table.
// ----------------------------------------------------------------------------
`default_nettype none
package srct_pkg;

  localparam int unsigned INDEX_BITS_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF = 8;
  localparam int unsigned OFF_W  = 44;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned VAL_W  = 64;

  localparam logic [SHIFT_W-1:0] ALIGN_RESET = 4'd3;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_DEC    = 3'd1,
    ACT_READ   = 3'd2,
    ACT_TAKE   = 3'd3,
    ACT_FIND   = 3'd4,
    ACT_REMOVE = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_OFF = 2'd1,
    ST_NEG     = 2'd2
  } status_t;

  localparam logic CFG_PAGE_START = 1'b0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_WRITE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;    // write zero at clear address
    logic capture;  // latch the input item
    logic rd;       // issue table read
    logic calc;     // register computed results
    logic wr;       // write back and present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/srct_ram.sv
// ----------------------------------------------------------------------------
// srct_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module srct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/srct_ctrl.sv
// ----------------------------------------------------------------------------
// srct_ctrl
// Sequencer: clearing pass after reset, then read, compute, write per item.
// ----------------------------------------------------------------------------
`default_nettype none
module srct_ctrl
  import srct_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = S_CALC;
      S_CALC:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      S_READ:  cmd.rd = 1'b1;
      S_CALC:  cmd.calc = 1'b1;
      S_WRITE: cmd.wr = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

### rtl/srct_dp.sv
// ----------------------------------------------------------------------------
// srct_dp
// Datapath: index check, table read, count arithmetic and write back.
// ----------------------------------------------------------------------------
`default_nettype none
module srct_dp
  import srct_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  output dp_sts_t                       sts,
  input  wire logic [2:0]               action,
  input  wire logic [OFF_W-1:0]         object_offset,
  input  wire logic signed [VAL_W-1:0]  delta,
  input  wire logic [OFF_W-1:0]         page_start,
  input  wire logic [SHIFT_W-1:0]       align_shift,
  output logic                          strobe,
  output logic signed [VAL_W-1:0]       count_value,
  output logic                          nonzero,
  output logic [1:0]                    status
);
  localparam int unsigned DEPTH = 1 << INDEX_BITS;
  localparam logic signed [VAL_W-1:0] SMAX = (64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1;
  localparam logic signed [VAL_W-1:0] SMIN = -SMAX - 64'sd1;
  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  // clearing pass counter, one extra bit to mark completion
  logic [INDEX_BITS:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !clr_cnt[INDEX_BITS]) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign sts.clear_done = clr_cnt[INDEX_BITS];

  // captured item
  logic [2:0]              act;
  logic signed [VAL_W-1:0] dlt;
  logic                    ok;
  logic [INDEX_BITS-1:0]   idx;

  logic [OFF_W-1:0] local_off, shifted, amask;
  always_comb begin
    local_off = object_offset - page_start;
    amask     = ~({OFF_W{1'b1}} << align_shift);
    shifted   = local_off >> align_shift;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= action;
      dlt <= delta;
      idx <= shifted[INDEX_BITS-1:0];
      ok  <= (object_offset >= page_start) && ((local_off & amask) == '0) &&
             ((shifted >> INDEX_BITS) == '0);
    end
  end

  // tables
  logic                    sm_we, bg_we;
  logic [INDEX_BITS-1:0]   addr;
  logic [COUNT_BITS-1:0]   sm_wd, sm_rd;
  logic [VAL_W-1:0]        bg_wd, bg_rd;

  srct_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_small (
    .clk(clk), .we(sm_we), .addr(addr), .wdata(sm_wd), .rdata(sm_rd)
  );
  srct_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_big (
    .clk(clk), .we(bg_we), .addr(addr), .wdata(bg_wd), .rdata(bg_rd)
  );

  // saturating 64-bit add
  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add = s[VAL_W] ? VMIN : VMAX;
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

  logic signed [VAL_W-1:0] sm, bg, total, t1;
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      total <= '0;
    end
    if (cmd.calc) begin
      total <= sat_add(sm, bg);
      t1    <= sat_add(sat_add(sm, bg), dlt);
    end
  end
  assign sm = {{(VAL_W-COUNT_BITS){sm_rd[COUNT_BITS-1]}}, sm_rd};
  assign bg = bg_rd;

  // write-back and result
  logic signed [VAL_W-1:0] ns, val;
  logic                    nz, wsm, wbg;
  logic [1:0]              st;
  logic signed [VAL_W-1:0] nbg;
  logic [COUNT_BITS-1:0]   nsm;
  always_comb begin
    ns  = (t1 > SMAX) ? SMAX : ((t1 < SMIN) ? SMIN : t1);
    val = '0; nz = 1'b0; st = ST_OK; wsm = 1'b0; wbg = 1'b0;
    nsm = '0; nbg = '0;
    if (act <= 3'(ACT_REMOVE)) begin
      if (!ok) begin
        st = ST_BAD_OFF;
      end else begin
        case (act)
          ACT_ADD: begin
            val = total; wsm = 1'b1; wbg = 1'b1;
            nsm = ns[COUNT_BITS-1:0]; nbg = t1 - ns;
          end
          ACT_DEC: begin
            if (bg < 0 || (bg == 0 && sm < 0)) begin
              st = ST_NEG;
            end else if (bg > 0) begin
              val = sat_add(bg, SMAX); wbg = 1'b1; nbg = bg - 64'sd1;
            end else begin
              val = sm;
              if (sm > 0) begin
                wsm = 1'b1; nsm = sm_rd - 1'b1;
              end
            end
          end
          ACT_READ: val = sm;
          ACT_TAKE: begin
            val = sm; wsm = 1'b1;
          end
          ACT_FIND: begin
            val = total; nz = (total != 0);
          end
          ACT_REMOVE: begin
            wsm = 1'b1; wbg = 1'b1;
          end
          default: val = '0;
        endcase
      end
    end
  end

  always_comb begin
    if (cmd.clear) begin
      addr  = clr_cnt[INDEX_BITS-1:0];
      sm_we = !clr_cnt[INDEX_BITS];
      bg_we = !clr_cnt[INDEX_BITS];
      sm_wd = '0;
      bg_wd = '0;
    end else begin
      addr  = idx;
      sm_we = cmd.wr && wsm;
      bg_we = cmd.wr && wbg;
      sm_wd = nsm;
      bg_wd = nbg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.wr;
    end
    if (cmd.wr) begin
      count_value <= val;
      nonzero     <= nz;
      status      <= st;
    end
  end
endmodule
`default_nettype wire

### rtl/split_saturating_ref_counter_table.sv
// ----------------------------------------------------------------------------
// split_saturating_ref_counter_table
// Per-object reference counts of one page, split into small and big parts.
// ----------------------------------------------------------------------------
// After reset, busy is high during a clearing pass over every table entry.
// Each item then goes from start to its result strobe through a table read,
// a compute step, a write-back through the single-port tables and an output
// register; busy is high from the read to the write-back. Results appear on
// count_value, nonzero and status with strobe, high for one cycle; the
// receiver cannot stall. Write configuration only while busy is low.
`default_nettype none
module split_saturating_ref_counter_table
  import srct_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              action,
  input  wire logic [OFF_W-1:0]        object_offset,
  input  wire logic signed [VAL_W-1:0] delta,
  output logic                         strobe,
  output logic signed [VAL_W-1:0]      count_value,
  output logic                         nonzero,
  output logic [1:0]                   status,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [OFF_W-1:0]        cfg_data
);
  logic [OFF_W-1:0]   page_start;
  logic [SHIFT_W-1:0] align_shift;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_start  <= '0;
      align_shift <= ALIGN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PAGE_START) begin
        page_start <= cfg_data;
      end else begin
        align_shift <= cfg_data[SHIFT_W-1:0];
      end
    end
  end

  srct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  srct_dp #(.INDEX_BITS(INDEX_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .action(action), .object_offset(object_offset), .delta(delta),
    .page_start(page_start), .align_shift(align_shift),
    .strobe(strobe), .count_value(count_value), .nonzero(nonzero),
    .status(status)
  );
endmodule
`default_nettype wire

### rtl/srct_checker.sv
// ----------------------------------------------------------------------------
// srct_checker
// Port-level checks of the counter table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module srct_checker
  import srct_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic       nonzero,
  input wire logic [1:0] status
);
  // an accepted item raises busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  // a result strobe follows each accepted item
  a_res: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##3 strobe) else $error("missing result");
  // strobe is a single pulse
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe too long");
  // nonzero only with ok status
  a_nz: assert property (@(posedge clk) disable iff (rst)
    strobe && nonzero |-> status == ST_OK) else $error("nonzero with error");
endmodule

bind split_saturating_ref_counter_table srct_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .nonzero(nonzero), .status(status)
);
`default_nettype wire
